[design/ntt_pkg.sv]
package ntt_pkg;

    localparam int SLOTS_DEFAULT   = 16;
    localparam int ID_BITS_DEFAULT = 64;

    localparam logic [15:0] DEDUP_RESET    = 16'd3000;
    localparam logic [31:0] DT_SINGLE_LO   = 32'd9500;
    localparam logic [31:0] DT_SINGLE_HI   = 32'd10500;
    localparam logic [31:0] DT_DOUBLE_LO   = 32'd19000;
    localparam logic [31:0] DT_DOUBLE_HI   = 32'd21000;
    localparam logic [13:0] PERIOD_MIN     = 14'd9800;
    localparam logic [13:0] PERIOD_MAX     = 14'd10200;
    localparam logic [13:0] PERIOD_DEFAULT = 14'd10000;
    localparam logic [17:0] SAMPLE_SPACING = 18'd1000;
    localparam int          DIV_STEPS      = 32;

    typedef enum logic [1:0] {
        REQ_SINGLE = 2'd0,
        REQ_BATCH  = 2'd1,
        REQ_QUERY  = 2'd2,
        REQ_NONE   = 2'd3
    } req_t;

    typedef enum logic {
        CFG_LEAD  = 1'b0,
        CFG_DEDUP = 1'b1
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_S_RD,
        ST_S_CMP,
        ST_PICK,
        ST_UPDATE,
        ST_Q_RD,
        ST_Q_CMP,
        ST_Q_DIV,
        ST_Q_CAND,
        ST_Q_OUT,
        ST_ZERO
    } state_t;

    // per-slot record, identifier kept apart since its width is a parameter
    typedef struct packed {
        logic [47:0] mac;
        logic [31:0] last_seen;
        logic [31:0] last_sample;
        logic [31:0] batch_start;
        logic [7:0]  batch_count;
        logic [31:0] first_x;
        logic [31:0] first_y;
        logic [31:0] first_z;
        logic [31:0] total;
        logic [13:0] period;
    } slot_rec_t;

    localparam int REC_W = $bits(slot_rec_t);

    typedef struct packed {
        logic latch;
        logic rd_scan;
        logic scan_step;
        logic pick;
        logic update;
        logic q_load;
        logic q_skip;
        logic q_cand;
        logic emit_query;
        logic emit_zero;
    } ntt_cmd_t;

    typedef struct packed {
        req_t req;
        logic scan_end;
        logic match;
        logic seen;
        logic need_div;
        logic div_busy;
    } ntt_stat_t;

endpackage

[design/node_tracking_table.sv]
// node tracking table
//
// request channel: a transaction is taken at a clock edge where start is high
// and busy is low; all request fields are sampled at that edge. busy stays
// high until the result is out, so one transaction is in flight at a time.
// result channel: done is high for exactly one cycle with all result fields
// valid; the receiver cannot stall and must take it in that cycle.
// config port: cfg_we with cfg_idx (0 lead time, 1 dedup window) and cfg_data,
// to be written only while idle; the block itself does not enforce this. no read-back.
// sequence from the accepting edge to the result: an event scans the slots in
// use, reading and then comparing each one since the record memory has a
// registered read, picks a slot if none matched and updates it; a query runs
// the 32-step remainder unit for each slot whose projected wake time is due,
// and an unused request type goes straight to a zero result. busy drops in the
// result cycle, so the next transaction can be taken at the result edge.
// reset: the slot count is cleared, so the table starts empty without a
// clearing pass; config returns to lead 0 and window 3000.
module node_tracking_table
    import ntt_pkg::*;
#(
    parameter int SLOTS   = SLOTS_DEFAULT,
    parameter int ID_BITS = ID_BITS_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    output logic               done,
    input  logic               cfg_we,
    input  logic               cfg_idx,
    input  logic [15:0]        cfg_data,
    input  logic [1:0]         req_type,
    input  logic [31:0]        now_ms,
    input  logic [63:0]        id_key,
    input  logic               id_present,
    input  logic [47:0]        mac_addr,
    input  logic               mac_present,
    input  logic [31:0]        sample_ts,
    input  logic [7:0]         batch_len,
    input  logic signed [31:0] first_x,
    input  logic signed [31:0] first_y,
    input  logic signed [31:0] first_z,
    output logic               is_new,
    output logic [3:0]         slot_index,
    output logic [31:0]        packet_total,
    output logic [13:0]        period_ms,
    output logic               wake_found,
    output logic [31:0]        wake_ms,
    output logic [31:0]        target_ms,
    output logic [3:0]         wake_slot
);

    ntt_cmd_t  cmd;
    ntt_stat_t stat;
    logic      ctrl_busy;

    // sequencer: scan, pick, update or per-slot projection
    ntt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (ctrl_busy)
    );

    // record memory, config, projection and result registers
    ntt_datapath #(
        .SLOTS   (SLOTS),
        .ID_BITS (ID_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_idx      (cfg_idx),
        .cfg_data     (cfg_data),
        .req_type     (req_type),
        .now_ms       (now_ms),
        .id_key       (id_key),
        .id_present   (id_present),
        .mac_addr     (mac_addr),
        .mac_present  (mac_present),
        .sample_ts    (sample_ts),
        .batch_len    (batch_len),
        .first_x      (first_x),
        .first_y      (first_y),
        .first_z      (first_z),
        .cmd          (cmd),
        .stat         (stat),
        .done         (done),
        .is_new       (is_new),
        .slot_index   (slot_index),
        .packet_total (packet_total),
        .period_ms    (period_ms),
        .wake_found   (wake_found),
        .wake_ms      (wake_ms),
        .target_ms    (target_ms),
        .wake_slot    (wake_slot)
    );

    assign busy = ctrl_busy;

    // a result only follows a transaction in flight
    assert property (@(posedge clk) disable iff (!rst_n) done |-> $past(busy))
        else $error("result without a transaction in flight");

    // an accepted transaction keeps the block busy
    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    // exactly one result per transaction
    assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("result strobe longer than one cycle");

    // wake_found stays low on event results flagged as new
    assert property (@(posedge clk) disable iff (!rst_n) (done && is_new) |-> !wake_found)
        else $error("wake fields set on an event result");

endmodule

[design/ntt_ram.sv]
module ntt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[design/ntt_rem.sv]
module ntt_rem
    import ntt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [13:0] divisor,
    output logic        busy,
    output logic [13:0] rem
);

    localparam int CNT_W = $clog2(DIV_STEPS + 1);

    logic [CNT_W-1:0] cnt_reg;
    logic [31:0]      dvd_reg;
    logic [13:0]      dsr_reg;
    logic [13:0]      rem_reg;
    logic [14:0]      trial;
    logic [14:0]      rem_next;

    // restoring step, one quotient bit a cycle
    always_comb
    begin
        trial = {rem_reg, dvd_reg[31]};
        if (trial >= {1'b0, dsr_reg})
        begin
            rem_next = trial - {1'b0, dsr_reg};
        end
        else
        begin
            rem_next = trial;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= CNT_W'(DIV_STEPS);
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            dvd_reg <= {dvd_reg[30:0], 1'b0};
            rem_reg <= rem_next[13:0];
        end
    end

    assign busy = (cnt_reg != '0);
    assign rem  = rem_reg;

endmodule

[design/ntt_ctrl.sv]
module ntt_ctrl
    import ntt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  ntt_stat_t stat,
    output ntt_cmd_t  cmd,
    output logic      busy
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                case (stat.req)
                    REQ_SINGLE, REQ_BATCH: state_next = ST_S_RD;
                    REQ_QUERY:             state_next = ST_Q_RD;
                    default:               state_next = ST_ZERO;
                endcase
            end
            ST_S_RD:   state_next = stat.scan_end ? ST_PICK : ST_S_CMP;
            ST_S_CMP:  state_next = stat.match ? ST_UPDATE : ST_S_RD;
            ST_PICK:   state_next = ST_UPDATE;
            ST_UPDATE: state_next = ST_IDLE;
            ST_Q_RD:   state_next = stat.scan_end ? ST_Q_OUT : ST_Q_CMP;
            ST_Q_CMP:
            begin
                if (!stat.seen)
                begin
                    state_next = ST_Q_RD;
                end
                else if (stat.need_div)
                begin
                    state_next = ST_Q_DIV;
                end
                else
                begin
                    state_next = ST_Q_CAND;
                end
            end
            ST_Q_DIV:  state_next = stat.div_busy ? ST_Q_DIV : ST_Q_CAND;
            ST_Q_CAND: state_next = ST_Q_RD;
            ST_Q_OUT:  state_next = ST_IDLE;
            ST_ZERO:   state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            ST_IDLE:   cmd.latch      = start;
            ST_S_RD:   cmd.rd_scan    = !stat.scan_end;
            ST_S_CMP:  cmd.scan_step  = 1'b1;
            ST_PICK:   cmd.pick       = 1'b1;
            ST_UPDATE: cmd.update     = 1'b1;
            ST_Q_RD:   cmd.rd_scan    = !stat.scan_end;
            ST_Q_CMP:
            begin
                cmd.q_load = 1'b1;
                cmd.q_skip = !stat.seen;
            end
            ST_Q_CAND: cmd.q_cand     = 1'b1;
            ST_Q_OUT:  cmd.emit_query = 1'b1;
            ST_ZERO:   cmd.emit_zero  = 1'b1;
            default:   cmd            = '0;
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

[design/ntt_datapath.sv]
module ntt_datapath
    import ntt_pkg::*;
#(
    parameter int SLOTS   = SLOTS_DEFAULT,
    parameter int ID_BITS = ID_BITS_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_idx,
    input  logic [15:0]        cfg_data,
    input  logic [1:0]         req_type,
    input  logic [31:0]        now_ms,
    input  logic [63:0]        id_key,
    input  logic               id_present,
    input  logic [47:0]        mac_addr,
    input  logic               mac_present,
    input  logic [31:0]        sample_ts,
    input  logic [7:0]         batch_len,
    input  logic signed [31:0] first_x,
    input  logic signed [31:0] first_y,
    input  logic signed [31:0] first_z,
    input  ntt_cmd_t           cmd,
    output ntt_stat_t          stat,
    output logic               done,
    output logic               is_new,
    output logic [3:0]         slot_index,
    output logic [31:0]        packet_total,
    output logic [13:0]        period_ms,
    output logic               wake_found,
    output logic [31:0]        wake_ms,
    output logic [31:0]        target_ms,
    output logic [3:0]         wake_slot
);

    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam int RW = ID_BITS + REC_W;

    // configuration
    logic [15:0] lead_reg;
    logic [15:0] win_reg;

    // latched request
    req_t        req_reg;
    logic [31:0] now_reg;
    logic [63:0] id_reg;
    logic        id_ok_reg;
    logic [47:0] mac_reg;
    logic        mac_ok_reg;
    logic [31:0] ts_reg;
    logic [7:0]  cnt_reg;
    logic [31:0] fx_reg;
    logic [31:0] fy_reg;
    logic [31:0] fz_reg;

    // table control
    logic [CW-1:0] used_reg;
    logic [CW-1:0] idx_reg;
    logic [AW-1:0] slot_reg;
    logic          fresh_reg;
    logic [AW-1:0] old_slot_reg;
    logic [31:0]   old_ls_reg;

    // query
    logic [31:0]   q_target_reg;
    logic [13:0]   q_per_reg;
    logic          q_need_reg;
    logic          best_found_reg;
    logic [31:0]   best_wake_reg;
    logic [31:0]   best_target_reg;
    logic [AW-1:0] best_slot_reg;

    // results
    logic        done_reg;
    logic        is_new_reg;
    logic [3:0]  slot_index_reg;
    logic [31:0] packet_total_reg;
    logic [13:0] period_reg;
    logic        wake_found_reg;
    logic [31:0] wake_ms_reg;
    logic [31:0] target_ms_reg;
    logic [3:0]  wake_slot_reg;

    // memory
    logic              ram_we;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [RW-1:0]     ram_wdata;
    logic [RW-1:0]     ram_rdata;
    logic [ID_BITS-1:0] rd_id;
    slot_rec_t         rd_rec;

    logic [ID_BITS+63:0] rd_id_ext;
    logic                hit;
    logic [31:0]         limit;

    // update datapath
    logic [ID_BITS-1:0] cur_id;
    slot_rec_t          cur;
    slot_rec_t          rec_next;
    logic [31:0]        dt;
    logic               sdup;
    logic               bdup;
    logic [31:0]        lst_b;
    logic [31:0]        lbs_b;
    logic [16:0]        p_sum;
    logic [13:0]        p_new;
    logic [13:0]        p_clamp;
    logic [17:0]        spacing;
    logic               new_flag;

    // query datapath
    logic [13:0] q_per;
    logic [31:0] q_t0;
    logic [31:0] q_tf;
    logic [31:0] q_wake;
    logic        div_busy;
    logic [13:0] div_rem;

    logic [AW+3:0] slot_ext;
    logic [AW+3:0] best_ext;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lead_reg <= '0;
            win_reg  <= DEDUP_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_idx))
                CFG_LEAD:  lead_reg <= cfg_data;
                CFG_DEDUP: win_reg  <= cfg_data;
                default:   lead_reg <= lead_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            req_reg    <= req_t'(req_type);
            now_reg    <= now_ms;
            id_reg     <= id_key;
            id_ok_reg  <= id_present && (id_key != '0);
            mac_reg    <= mac_addr;
            mac_ok_reg <= mac_present;
            ts_reg     <= sample_ts;
            cnt_reg    <= batch_len;
            fx_reg     <= first_x;
            fy_reg     <= first_y;
            fz_reg     <= first_z;
        end
    end

    assign ram_re    = cmd.rd_scan;
    assign ram_raddr = idx_reg[AW-1:0];
    assign ram_we    = cmd.update;
    assign ram_wdata = {cur_id, rec_next};

    ntt_ram #(
        .WIDTH (RW),
        .DEPTH (SLOTS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slot_reg),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_id     = ram_rdata[RW-1 -: ID_BITS];
    assign rd_rec    = slot_rec_t'(ram_rdata[REC_W-1:0]);
    assign rd_id_ext = {64'd0, rd_id};
    assign hit       = (id_ok_reg && (rd_id_ext[63:0] == id_reg))
                    || (mac_ok_reg && (rd_rec.mac == mac_reg));
    assign limit     = now_reg + {16'd0, lead_reg};

    // query projection of the entry just read
    assign q_per  = (rd_rec.period != '0) ? rd_rec.period : PERIOD_DEFAULT;
    assign q_t0   = rd_rec.last_seen + {18'd0, q_per};
    assign q_tf   = q_need_reg ? (limit - {18'd0, div_rem} + {18'd0, q_per_reg})
                               : q_target_reg;
    assign q_wake = q_tf - {16'd0, lead_reg};

    ntt_rem u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.q_load && (rd_rec.last_seen != '0) && (q_t0 <= limit)),
        .dividend (limit - q_t0),
        .divisor  (q_per),
        .busy     (div_busy),
        .rem      (div_rem)
    );

    always_comb
    begin
        stat.req      = req_reg;
        stat.scan_end = (idx_reg == used_reg);
        stat.match    = hit;
        stat.seen     = (rd_rec.last_seen != '0);
        stat.need_div = (q_t0 <= limit);
        stat.div_busy = div_busy;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
        end
        else if (cmd.pick && (used_reg != CW'(SLOTS)))
        begin
            used_reg <= used_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            idx_reg        <= '0;
            best_found_reg <= 1'b0;
        end
        else if (cmd.scan_step)
        begin
            if (hit)
            begin
                slot_reg  <= idx_reg[AW-1:0];
                fresh_reg <= 1'b0;
            end
            else
            begin
                if ((idx_reg == '0) || (rd_rec.last_seen < old_ls_reg))
                begin
                    old_slot_reg <= idx_reg[AW-1:0];
                    old_ls_reg   <= rd_rec.last_seen;
                end
                idx_reg <= idx_reg + 1'b1;
            end
        end
        else if (cmd.pick)
        begin
            fresh_reg <= 1'b1;
            slot_reg  <= (used_reg != CW'(SLOTS)) ? used_reg[AW-1:0] : old_slot_reg;
        end
        else if (cmd.q_skip)
        begin
            idx_reg <= idx_reg + 1'b1;
        end
        else if (cmd.q_load)
        begin
            q_target_reg <= q_t0;
            q_per_reg    <= q_per;
            q_need_reg   <= (q_t0 <= limit);
        end
        else if (cmd.q_cand)
        begin
            if (!best_found_reg || (q_wake < best_wake_reg))
            begin
                best_found_reg  <= 1'b1;
                best_wake_reg   <= q_wake;
                best_target_reg <= q_tf;
                best_slot_reg   <= idx_reg[AW-1:0];
            end
            idx_reg <= idx_reg + 1'b1;
        end
    end

    // record that the event works on: a new slot or the one read by the scan
    always_comb
    begin
        if (fresh_reg)
        begin
            cur_id  = id_ok_reg ? id_reg[ID_BITS-1:0] : '0;
            cur     = '0;
            cur.mac = mac_ok_reg ? mac_reg : '0;
        end
        else
        begin
            cur_id = rd_id;
            cur    = rd_rec;
        end
    end

    always_comb
    begin
        dt       = now_reg - cur.last_seen;
        sdup     = (ts_reg != '0) && (ts_reg == cur.last_sample);
        bdup     = (cur.last_seen != '0) && (dt < {16'd0, win_reg})
                && (cnt_reg == cur.batch_count) && (fx_reg == cur.first_x)
                && (fy_reg == cur.first_y) && (fz_reg == cur.first_z);
        // start time going backward drops the stored timestamps
        if ((cur.last_sample != '0) && (ts_reg < cur.batch_start))
        begin
            lst_b = '0;
            lbs_b = '0;
        end
        else
        begin
            lst_b = cur.last_sample;
            lbs_b = cur.batch_start;
        end

        p_new = cur.period;
        p_sum = '0;
        if (cur.last_seen != '0)
        begin
            if ((dt >= DT_SINGLE_LO) && (dt <= DT_SINGLE_HI))
            begin
                p_sum = {cur.period, 3'b000} - {3'b000, cur.period} + {3'b000, dt[13:0]};
                p_new = (cur.period == '0) ? dt[13:0] : p_sum[16:3];
            end
            else if ((dt >= DT_DOUBLE_LO) && (dt <= DT_DOUBLE_HI) && (cur.period != '0))
            begin
                p_sum = {cur.period, 3'b000} - {3'b000, cur.period} + {3'b000, dt[14:1]};
                p_new = p_sum[16:3];
            end
        end
        p_clamp = ((p_new < PERIOD_MIN) || (p_new > PERIOD_MAX)) ? PERIOD_DEFAULT : p_new;
        spacing = (cnt_reg == '0) ? '0 : ({10'd0, cnt_reg - 8'd1} * SAMPLE_SPACING);

        rec_next           = cur;
        rec_next.last_seen = now_reg;
        new_flag           = 1'b0;
        case (req_reg)
            REQ_SINGLE:
            begin
                if (!sdup)
                begin
                    new_flag = 1'b1;
                    rec_next.total = cur.total + 32'd1;
                    if (ts_reg != '0)
                    begin
                        rec_next.last_sample = ts_reg;
                    end
                end
            end
            REQ_BATCH:
            begin
                rec_next.last_sample = lst_b;
                rec_next.batch_start = lbs_b;
                if (!bdup)
                begin
                    new_flag             = 1'b1;
                    rec_next.period      = p_clamp;
                    rec_next.batch_start = ts_reg;
                    rec_next.batch_count = cnt_reg;
                    rec_next.first_x     = fx_reg;
                    rec_next.first_y     = fy_reg;
                    rec_next.first_z     = fz_reg;
                    rec_next.last_sample = ts_reg + {14'd0, spacing};
                    rec_next.total       = cur.total + {24'd0, cnt_reg};
                end
            end
            default:
            begin
                new_flag = 1'b0;
            end
        endcase
    end

    assign slot_ext = {4'd0, slot_reg};
    assign best_ext = {4'd0, best_slot_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.update || cmd.emit_query || cmd.emit_zero;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            is_new_reg       <= new_flag;
            slot_index_reg   <= slot_ext[3:0];
            packet_total_reg <= rec_next.total;
            period_reg       <= rec_next.period;
            wake_found_reg   <= 1'b0;
            wake_ms_reg      <= '0;
            target_ms_reg    <= '0;
            wake_slot_reg    <= '0;
        end
        else if (cmd.emit_query || cmd.emit_zero)
        begin
            is_new_reg       <= 1'b0;
            slot_index_reg   <= '0;
            packet_total_reg <= '0;
            period_reg       <= '0;
            wake_found_reg   <= cmd.emit_query && best_found_reg;
            wake_ms_reg      <= (cmd.emit_query && best_found_reg) ? best_wake_reg : '0;
            target_ms_reg    <= (cmd.emit_query && best_found_reg) ? best_target_reg : '0;
            wake_slot_reg    <= (cmd.emit_query && best_found_reg) ? best_ext[3:0] : '0;
        end
    end

    assign done         = done_reg;
    assign is_new       = is_new_reg;
    assign slot_index   = slot_index_reg;
    assign packet_total = packet_total_reg;
    assign period_ms    = period_reg;
    assign wake_found   = wake_found_reg;
    assign wake_ms      = wake_ms_reg;
    assign target_ms    = target_ms_reg;
    assign wake_slot    = wake_slot_reg;

endmodule
